[hw/rtl/gad_pkg.sv]
// Shared types, register indexes, reset values and helper functions for the
// gesture axis detector. No dependencies; used by every other file.
package gad_pkg;

    localparam int AccelWidth = 13;
    localparam int CoefWidth  = 8;
    localparam int UnitWidth  = 10;
    localparam int ThrWidth   = CoefWidth + UnitWidth;
    localparam int Mag10Width = 16;
    localparam int RunWidth   = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 24;

    localparam logic [23:0] PosCoefsRst   = 24'h0B0D0C;
    localparam logic [23:0] NegCoefsRst   = 24'h0D0B0C;
    localparam logic [23:0] QuietCoefsRst = 24'h020202;
    localparam logic [9:0]  UnitLevelRst  = 10'd255;
    localparam logic [1:0]  StartAxisRst  = 2'd1;
    localparam logic [15:0] SettleLenRst  = 16'd1000;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_POS_COEFS   = 3'd0,
        CFG_NEG_COEFS   = 3'd1,
        CFG_QUIET_COEFS = 3'd2,
        CFG_UNIT_LEVEL  = 3'd3,
        CFG_START_AXIS  = 3'd4,
        CFG_SETTLE_LEN  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_3 = 2'd3
    } axis_t;

    typedef enum logic [2:0] {
        DIR_NONE = 3'd0,
        DIR_XP   = 3'd1,
        DIR_XN   = 3'd2,
        DIR_YP   = 3'd3,
        DIR_YN   = 3'd4,
        DIR_ZP   = 3'd5,
        DIR_ZN   = 3'd6
    } dir_t;

    typedef struct packed {
        logic [23:0] pos_coefs;
        logic [23:0] neg_coefs;
        logic [23:0] quiet_coefs;
        logic [9:0]  unit_level;
        logic [1:0]  start_axis;
        logic [15:0] settle_length;
    } cfg_t;

    typedef struct packed {
        logic                emit;
        logic [2:0]          direction_code;
        logic [1:0]          chosen_axis;
        logic                settling;
        logic [RunWidth-1:0] quiet_run;
    } eval_t;

    function automatic logic [AccelWidth-1:0] abs_mag(input logic signed [AccelWidth-1:0] v);
        abs_mag = v[AccelWidth-1] ? AccelWidth'(-v) : AccelWidth'(v);
    endfunction

    function automatic logic [CoefWidth-1:0] coef_sel(input logic [23:0] packed_coefs,
                                                      input logic [1:0] axis);
        logic [CoefWidth-1:0] c;
        unique case (axis)
            AXIS_X:  c = packed_coefs[7:0];
            AXIS_Y:  c = packed_coefs[15:8];
            default: c = packed_coefs[23:16];
        endcase
        coef_sel = c;
    endfunction

    // Seed at the start axis (3 acts as x), then visit y and z in order,
    // taking an axis only on a strict improvement.
    function automatic logic [1:0] pick_axis(input logic [AccelWidth-1:0] mx,
                                             input logic [AccelWidth-1:0] my,
                                             input logic [AccelWidth-1:0] mz,
                                             input logic [1:0] start,
                                             input logic want_max);
        logic [1:0]            best;
        logic [AccelWidth-1:0] best_mag;
        unique case (start)
            AXIS_Y:  begin best = AXIS_Y; best_mag = my; end
            AXIS_Z:  begin best = AXIS_Z; best_mag = mz; end
            default: begin best = AXIS_X; best_mag = mx; end
        endcase
        if (want_max ? (my > best_mag) : (my < best_mag))
        begin
            best     = AXIS_Y;
            best_mag = my;
        end
        if (want_max ? (mz > best_mag) : (mz < best_mag))
        begin
            best = AXIS_Z;
        end
        pick_axis = best;
    endfunction

endpackage

[hw/rtl/gad_cfg_regs.sv]
// Configuration register file of the gesture axis detector.
// Depends on gad_pkg (cfg_t, register indexes, reset values).
module gad_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [gad_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [gad_pkg::CfgDataWidth-1:0] cfg_data,
    output gad_pkg::cfg_t                    cfg
);

    gad_pkg::cfg_t cfg_reg;
    gad_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gad_pkg::CFG_POS_COEFS:   cfg_next.pos_coefs     = cfg_data;
                gad_pkg::CFG_NEG_COEFS:   cfg_next.neg_coefs     = cfg_data;
                gad_pkg::CFG_QUIET_COEFS: cfg_next.quiet_coefs   = cfg_data;
                gad_pkg::CFG_UNIT_LEVEL:  cfg_next.unit_level    = cfg_data[9:0];
                gad_pkg::CFG_START_AXIS:  cfg_next.start_axis    = cfg_data[1:0];
                gad_pkg::CFG_SETTLE_LEN:  cfg_next.settle_length = cfg_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_coefs     <= gad_pkg::PosCoefsRst;
            cfg_reg.neg_coefs     <= gad_pkg::NegCoefsRst;
            cfg_reg.quiet_coefs   <= gad_pkg::QuietCoefsRst;
            cfg_reg.unit_level    <= gad_pkg::UnitLevelRst;
            cfg_reg.start_axis    <= gad_pkg::StartAxisRst;
            cfg_reg.settle_length <= gad_pkg::SettleLenRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/gad_eval.sv]
// Per-sample evaluation: max-axis direction test when idle, min-axis quiet
// test and run counter while settling. Combinational; depends on gad_pkg.
module gad_eval (
    input  gad_pkg::cfg_t                        cfg,
    input  logic signed [gad_pkg::AccelWidth-1:0] accel_x,
    input  logic signed [gad_pkg::AccelWidth-1:0] accel_y,
    input  logic signed [gad_pkg::AccelWidth-1:0] accel_z,
    input  logic                                 tick,
    input  logic                                 settling,
    input  logic [gad_pkg::RunWidth-1:0]         quiet_run,
    output gad_pkg::eval_t                       result
);

    logic [gad_pkg::AccelWidth-1:0] mag_x, mag_y, mag_z, mag_sel;
    logic [gad_pkg::Mag10Width-1:0] mag10;
    logic [gad_pkg::ThrWidth-1:0]   thr_a, thr_b;
    logic [gad_pkg::CoefWidth-1:0]  coef_a, coef_b;
    logic [1:0]                     axis_sel;
    logic                           neg_sel;
    logic                           over_a, over_b, is_quiet;
    logic [gad_pkg::RunWidth-1:0]   run_inc;

    always_comb
    begin
        mag_x = gad_pkg::abs_mag(accel_x);
        mag_y = gad_pkg::abs_mag(accel_y);
        mag_z = gad_pkg::abs_mag(accel_z);

        // Max search when idle, min search while settling.
        axis_sel = gad_pkg::pick_axis(mag_x, mag_y, mag_z, cfg.start_axis, !settling);

        unique case (axis_sel)
            gad_pkg::AXIS_X: begin mag_sel = mag_x; neg_sel = accel_x[gad_pkg::AccelWidth-1]; end
            gad_pkg::AXIS_Y: begin mag_sel = mag_y; neg_sel = accel_y[gad_pkg::AccelWidth-1]; end
            default:         begin mag_sel = mag_z; neg_sel = accel_z[gad_pkg::AccelWidth-1]; end
        endcase

        // 10*mag as shift-add
        mag10 = (gad_pkg::Mag10Width'(mag_sel) << 3) + (gad_pkg::Mag10Width'(mag_sel) << 1);

        // Threshold A: positive coef (idle) or quiet coef (settling); B: negative coef.
        coef_a = settling ? gad_pkg::coef_sel(cfg.quiet_coefs, axis_sel)
                          : gad_pkg::coef_sel(cfg.pos_coefs, axis_sel);
        coef_b = gad_pkg::coef_sel(cfg.neg_coefs, axis_sel);
        thr_a  = gad_pkg::ThrWidth'(coef_a) * gad_pkg::ThrWidth'(cfg.unit_level);
        thr_b  = gad_pkg::ThrWidth'(coef_b) * gad_pkg::ThrWidth'(cfg.unit_level);

        // 10*v > P holds only for positive v; 10*v < -N only for negative v.
        over_a   = !neg_sel && (mag_sel != '0) && (gad_pkg::ThrWidth'(mag10) > thr_a);
        over_b   = neg_sel && (gad_pkg::ThrWidth'(mag10) > thr_b);
        is_quiet = gad_pkg::ThrWidth'(mag10) < thr_a;
        run_inc  = is_quiet ? quiet_run + 1'b1 : '0;

        result.chosen_axis = axis_sel;
        result.settling    = settling;
        result.quiet_run   = quiet_run;
        if (settling)
        begin
            result.emit           = 1'b0;
            result.direction_code = gad_pkg::DIR_NONE;
            if (run_inc >= cfg.settle_length)
            begin
                result.settling  = 1'b0;
                result.quiet_run = '0;
            end
            else
            begin
                result.quiet_run = run_inc;
            end
        end
        else
        begin
            result.emit = tick;
            if (over_a)
                result.direction_code = {axis_sel, 1'b0} + 3'd1;
            else if (over_b)
                result.direction_code = {axis_sel, 1'b0} + 3'd2;
            else
                result.direction_code = gad_pkg::DIR_NONE;
            if (tick && (over_a || over_b))
            begin
                result.settling  = 1'b1;
                result.quiet_run = '0;
            end
        end
    end

endmodule

[hw/rtl/gesture_axis_detector_unit.sv]
// Gesture axis detector top level: input beat register, evaluation, result register.
// Depends on gad_pkg, gad_cfg_regs and gad_eval.
// An accepted beat's result is loaded into the result register once that is free or being drained.
// Throughput: one sample per cycle while the result side takes beats.
// Reset (rst_n low, asynchronous): idle, quiet run cleared, no beats held,
// configuration registers back to their documented defaults.
module gesture_axis_detector_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [12:0] accel_x, [25:13] accel_y, [38:26] accel_z, [39] zero
    input  logic [0:0]  s_axis_tuser,   // [0] tick
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] direction_code, [4:3] chosen_axis, [7:5] zero
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [gad_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [gad_pkg::CfgDataWidth-1:0] cfg_data
);

    gad_pkg::cfg_t  cfg;
    gad_pkg::eval_t eval;

    // Input beat register
    logic                                 in_valid_reg, in_valid_next;
    logic signed [gad_pkg::AccelWidth-1:0] ax_reg, ay_reg, az_reg;
    logic                                 tick_reg;

    // Detector state
    logic                           settling_reg, settling_next;
    logic [gad_pkg::RunWidth-1:0]   quiet_run_reg, quiet_run_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [2:0] code_reg;
    logic [1:0] axis_reg;

    logic advance;
    logic take_in;
    logic load_out;

    // Config writes are always taken; the user keeps the block idle whenever they arrive (unenforced).
    assign cfg_ready = 1'b1;

    gad_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gad_eval u_eval (
        .cfg       (cfg),
        .accel_x   (ax_reg),
        .accel_y   (ay_reg),
        .accel_z   (az_reg),
        .tick      (tick_reg),
        .settling  (settling_reg),
        .quiet_run (quiet_run_reg),
        .result    (eval)
    );

    // The held sample moves on whenever the result register is free or being
    // drained; the input register refills in the same cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign load_out      = in_valid_reg && advance && eval.emit;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        settling_next  = settling_reg;
        quiet_run_next = quiet_run_reg;
        if (in_valid_reg && advance)
        begin
            settling_next  = eval.settling;
            quiet_run_next = eval.quiet_run;
        end
        out_valid_next = advance ? (in_valid_reg && eval.emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            settling_reg  <= 1'b0;
            quiet_run_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            settling_reg  <= settling_next;
            quiet_run_reg <= quiet_run_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            ax_reg   <= s_axis_tdata[12:0];
            ay_reg   <= s_axis_tdata[25:13];
            az_reg   <= s_axis_tdata[38:26];
            tick_reg <= s_axis_tuser[0];
        end
        if (load_out)
        begin
            code_reg <= eval.direction_code;
            axis_reg <= eval.chosen_axis;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, axis_reg, code_reg};

endmodule

[test/gesture_axis_detector_unit_tb.sv]
// Self-checking testbench for gesture_axis_detector_unit: directed and random sample
// beats, stalls on both streams, and checks against an in-bench model of the detector.
// Depends on gad_pkg and the gesture_axis_detector_unit RTL.
module gesture_axis_detector_unit_tb;

    localparam int CycleLimit = 300000;
    localparam int HoldCycles = 200;
    localparam int SettleWait = 10;
    localparam logic [gad_pkg::CfgIdxWidth-1:0] CfgIdxSpare = 3'd6;

    typedef struct {
        gad_pkg::dir_t  code;
        gad_pkg::axis_t axis;
    } gesture_t;

    // Model of the detector plus the queue of results still owed by the block.
    class gesture_tracker;
        logic [23:0] pos_coefs     = gad_pkg::PosCoefsRst;
        logic [23:0] neg_coefs     = gad_pkg::NegCoefsRst;
        logic [23:0] quiet_coefs   = gad_pkg::QuietCoefsRst;
        logic [9:0]  unit_level    = gad_pkg::UnitLevelRst;
        logic [1:0]  start_axis    = gad_pkg::StartAxisRst;
        logic [15:0] settle_length = gad_pkg::SettleLenRst;
        bit          settling      = 1'b0;
        logic [15:0] quiet_run     = '0;
        gesture_t    pending[$];
        int          errors        = 0;

        function void set_register(logic [gad_pkg::CfgIdxWidth-1:0] idx, logic [23:0] value);
            case (idx)
                gad_pkg::CFG_POS_COEFS:   pos_coefs     = value;
                gad_pkg::CFG_NEG_COEFS:   neg_coefs     = value;
                gad_pkg::CFG_QUIET_COEFS: quiet_coefs   = value;
                gad_pkg::CFG_UNIT_LEVEL:  unit_level    = value[9:0];
                gad_pkg::CFG_START_AXIS:  start_axis    = value[1:0];
                gad_pkg::CFG_SETTLE_LEN:  settle_length = value[15:0];
                default: ;
            endcase
        endfunction

        function int coef(logic [23:0] coefs, int a);
            return int'(coefs[8*a +: 8]);
        endfunction

        // Seed at the start axis (the spare code acts as x), strict compare only.
        function int search(int mag[3], bit want_max);
            int best;
            best = (start_axis == gad_pkg::AXIS_3) ? 0 : int'(start_axis);
            for (int a = 1; a < 3; a++)
                if (want_max ? (mag[a] > mag[best]) : (mag[a] < mag[best]))
                    best = a;
            return best;
        endfunction

        // Largest magnitude that is quiet on every axis.
        function int quiet_margin();
            int lim;
            lim = coef(quiet_coefs, 0);
            for (int a = 1; a < 3; a++)
                if (coef(quiet_coefs, a) < lim)
                    lim = coef(quiet_coefs, a);
            lim = lim * int'(unit_level);
            if (lim <= 0)
                return 0;
            return ((lim - 1) / 10 > 4095) ? 4095 : (lim - 1) / 10;
        endfunction

        function int activity_level(int a, bit neg);
            return coef(neg ? neg_coefs : pos_coefs, a) * int'(unit_level) / 10;
        endfunction

        function void note_sample(logic signed [12:0] x, logic signed [12:0] y,
                                  logic signed [12:0] z, logic tick);
            int       v[3];
            int       mag[3];
            int       a;
            int       unit;
            int       code;
            gesture_t g;
            v[0] = int'(x);
            v[1] = int'(y);
            v[2] = int'(z);
            unit = int'(unit_level);
            for (int i = 0; i < 3; i++)
                mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (settling) begin
                a = search(mag, 1'b0);
                if (mag[a] * 10 < coef(quiet_coefs, a) * unit)
                    quiet_run = quiet_run + 16'd1;
                else
                    quiet_run = '0;
                if (quiet_run >= settle_length) begin
                    settling  = 1'b0;
                    quiet_run = '0;
                end
                return;
            end
            if (!tick)
                return;
            a    = search(mag, 1'b1);
            code = 0;
            if (v[a] * 10 > coef(pos_coefs, a) * unit)
                code = 2 * a + 1;
            else if (v[a] * 10 < -(coef(neg_coefs, a) * unit))
                code = 2 * a + 2;
            if (code != 0) begin
                settling  = 1'b1;
                quiet_run = '0;
            end
            g.code = gad_pkg::dir_t'(code);
            g.axis = gad_pkg::axis_t'(a);
            pending.push_back(g);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(logic [7:0] beat);
            gesture_t g;
            if (pending.size() == 0) begin
                report($sformatf("result beat %h with nothing pending", beat));
                return;
            end
            g = pending.pop_front();
            if (beat[2:0] !== g.code)
                report($sformatf("direction_code %0d, want %0d", beat[2:0], g.code));
            if (beat[4:3] !== g.axis)
                report($sformatf("chosen_axis %0d, want %0d", beat[4:3], g.axis));
            if (beat[7:5] !== 3'b000)
                report($sformatf("pad bits %b not zero", beat[7:5]));
        endtask
    endclass

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [39:0]                      s_axis_tdata  = '0;
    logic [0:0]                       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [7:0]                       m_axis_tdata;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [gad_pkg::CfgIdxWidth-1:0]  cfg_index     = '0;
    logic [gad_pkg::CfgDataWidth-1:0] cfg_data      = '0;

    gesture_tracker sb;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    bit             hold_req    = 1'b0;
    int             cycle_count = 0;

    gesture_axis_detector_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("gesture_axis_detector_unit_tb: errors");
            $finish;
        end
    end

    // Handshakes are sampled at the falling edge, where everything driven at the
    // rising edge has settled; the beat then moves at the next rising edge.
    initial
    begin
        forever begin
            @(negedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Result side: random back-pressure, or a long hold when asked for.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic signed [12:0] axis_value(int mag, bit neg);
        return neg ? 13'(-mag) : 13'(mag);
    endfunction

    task automatic write_register(logic [gad_pkg::CfgIdxWidth-1:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(int x, int y, int z, logic tick);
        logic signed [12:0] xs;
        logic signed [12:0] ys;
        logic signed [12:0] zs;
        xs = 13'(x);
        ys = 13'(y);
        zs = 13'(z);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 40'({$urandom, $urandom});
            s_axis_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, zs, ys, xs};
        s_axis_tuser  <= tick;
        @(negedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sb.note_sample(xs, ys, zs, tick);
    endtask

    // Stop offering, let every owed result come out, then give the block time
    // to finish a beat that owes nothing.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SettleWait) @(posedge clk);
    endtask

    // Mostly gesture-shaped traffic: ticks with one dominant axis near its
    // threshold while idle, quiet samples while settling, some noise in both.
    task automatic send_random_sample();
        logic signed [12:0] s[3];
        logic               tk;
        int                 a;
        int                 lvl;
        int                 q;
        bit                 neg;
        if (sb.settling) begin
            tk = 1'($urandom_range(1));
            if ($urandom_range(99) < 85) begin
                q = sb.quiet_margin();
                for (int i = 0; i < 3; i++)
                    s[i] = axis_value(int'($urandom_range(q)), 1'($urandom_range(1)));
                if ($urandom_range(99) < 30)
                    s[$urandom_range(2)] = 13'($urandom);
            end else begin
                for (int i = 0; i < 3; i++)
                    s[i] = 13'($urandom);
            end
        end else begin
            tk  = ($urandom_range(99) < 85);
            a   = int'($urandom_range(2));
            neg = 1'($urandom_range(1));
            case ($urandom_range(2))
                0: for (int i = 0; i < 3; i++)
                    s[i] = 13'($urandom);
                1: begin
                    lvl = sb.activity_level(a, neg) + int'($urandom_range(4)) - 2;
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > (neg ? 4096 : 4095))
                        lvl = neg ? 4096 : 4095;
                    for (int i = 0; i < 3; i++)
                        s[i] = axis_value(int'($urandom_range(lvl)), 1'($urandom_range(1)));
                    s[a] = axis_value(lvl, neg);
                end
                default: for (int i = 0; i < 3; i++)
                    s[i] = axis_value(int'($urandom_range(40)), 1'($urandom_range(1)));
            endcase
        end
        send_sample(int'(s[0]), int'(s[1]), int'(s[2]), tk);
    endtask

    // Phase 0: everything at its floor, phase 1: everything at its ceiling
    // (nothing can fire), later phases random with coefficients that fire often.
    task automatic configure_phase(int p);
        logic [23:0] pos;
        logic [23:0] neg;
        logic [23:0] quiet;
        logic [9:0]  unit;
        logic [1:0]  start;
        logic [15:0] settle;
        if (p == 0) begin
            pos = '0; neg = '0; quiet = '0; unit = 10'd1; start = gad_pkg::AXIS_X;
            settle = '0;
        end else if (p == 1) begin
            pos = '1; neg = '1; quiet = '1; unit = '1; start = gad_pkg::AXIS_3;
            settle = '1;
        end else begin
            for (int b = 0; b < 3; b++) begin
                pos[8*b +: 8]   = ($urandom_range(9) < 8) ? 8'($urandom_range(24))
                                                          : 8'($urandom);
                neg[8*b +: 8]   = ($urandom_range(9) < 8) ? 8'($urandom_range(24))
                                                          : 8'($urandom);
                quiet[8*b +: 8] = 8'($urandom_range(40, 1));
            end
            unit   = ($urandom_range(9) < 6) ? 10'($urandom_range(400, 100))
                                             : 10'($urandom_range(1023, 1));
            start  = 2'($urandom_range(3));
            settle = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
        end
        write_register(gad_pkg::CFG_START_AXIS, 24'(start));
        write_register(gad_pkg::CFG_POS_COEFS, pos);
        write_register(gad_pkg::CFG_NEG_COEFS, neg);
        write_register(gad_pkg::CFG_QUIET_COEFS, quiet);
        write_register(gad_pkg::CFG_UNIT_LEVEL, 24'(unit));
        write_register(gad_pkg::CFG_SETTLE_LEN, 24'(settle));
        if (p == 3)
            write_register(CfgIdxSpare, 24'($urandom));
    endtask

    task automatic run_directed();
        // search from x so that every axis can win
        write_register(gad_pkg::CFG_START_AXIS, 24'(gad_pkg::AXIS_X));
        write_register(gad_pkg::CFG_SETTLE_LEN, 24'd2);
        send_sample(0, 0, 0, 1'b0);           // idle, no tick: nothing
        send_sample(4095, 0, 0, 1'b1);        // x+
        send_sample(0, 0, 0, 1'b1);           // tick ignored while settling
        send_sample(0, 0, 0, 1'b0);
        send_sample(-4096, 5, -5, 1'b1);      // x-
        send_sample(1000, 1000, 1000, 1'b0);  // noisy, quiet run restarts
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 4095, 0, 1'b1);        // y+
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, -4096, 0, 1'b1);       // y-
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 4095, 1'b1);        // z+
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(1, 2, -4096, 1'b1);       // z-
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(100, -100, 100, 1'b1);    // three-way tie, below threshold
        drain();
        // spare start code, zero unit level, zero settle length, unused index
        write_register(gad_pkg::CFG_START_AXIS, 24'(gad_pkg::AXIS_3));
        write_register(gad_pkg::CFG_UNIT_LEVEL, 24'd0);
        write_register(gad_pkg::CFG_SETTLE_LEN, 24'd0);
        write_register(CfgIdxSpare, 24'hFFFFFF);
        send_sample(-7, 7, 0, 1'b1);          // zero threshold fires, x wins the tie
        send_sample(5, 5, 5, 1'b1);           // settling ends after one sample
        send_sample(0, 0, 0, 1'b1);           // zero reading: no direction
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 77 : 0;
            rx_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 25 : 0;
            for (int p = 0; p < 5; p++) begin
                // back to idle before the coefficients change under the block
                while (sb.settling)
                    send_sample(0, 0, 0, 1'($urandom_range(1)));
                drain();
                configure_phase(p);
                if (p == 2)
                    hold_req = 1'b1;
                repeat (110) send_random_sample();
            end
        end
        drain();
        if (sb.errors == 0)
            $display("gesture_axis_detector_unit_tb: clean");
        else
            $display("gesture_axis_detector_unit_tb: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/gad_pkg.sv
hw/rtl/gad_cfg_regs.sv
hw/rtl/gad_eval.sv
hw/rtl/gesture_axis_detector_unit.sv
test/gesture_axis_detector_unit_tb.sv
